// File: hw/rtl/console_path_normalizer_defines.svh
// ----------------------------------------------------------------------------
// console path normalizer assertion macros
// shared property forms for the checker, clocked on clk, off during rst
// ----------------------------------------------------------------------------
`ifndef CONSOLE_PATH_NORMALIZER_DEFINES_SVH
`define CONSOLE_PATH_NORMALIZER_DEFINES_SVH

// same-cycle implication
`define CPN_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("cpn check failed");

// next-cycle implication
`define CPN_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("cpn check failed");

`endif

// File: hw/rtl/cpn_pkg.sv
// ----------------------------------------------------------------------------
// cpn_pkg
// types, character constants and helper functions of the path normalizer
// ----------------------------------------------------------------------------
package cpn_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned MAX_RESULTS = 16;

  localparam logic [1:0] KIND_ALIAS = 2'd0;
  localparam logic [1:0] KIND_REL   = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE = 3'd2;
  localparam logic [2:0] ST_DRIVE      = 3'd3;
  localparam logic [2:0] ST_INVALID    = 3'd4;
  localparam logic [2:0] ST_TRAVERSAL  = 3'd5;

  localparam byte_t CH_SLASH   = 8'h2F;
  localparam byte_t CH_BSLASH  = 8'h5C;
  localparam byte_t CH_DOT     = 8'h2E;
  localparam byte_t CH_COLON   = 8'h3A;
  localparam byte_t CH_STAR    = 8'h2A;
  localparam byte_t CH_QUEST   = 8'h3F;
  localparam byte_t CH_QUOTE   = 8'h22;
  localparam byte_t CH_LT      = 8'h3C;
  localparam byte_t CH_GT      = 8'h3E;
  localparam byte_t CH_PIPE    = 8'h7C;
  localparam byte_t CH_SPACE   = 8'h20;
  localparam byte_t CH_UP_A    = 8'h41;
  localparam byte_t CH_UP_D    = 8'h44;
  localparam byte_t CH_UP_Z    = 8'h5A;
  localparam byte_t CH_LO_A    = 8'h61;
  localparam byte_t CH_LO_Z    = 8'h7A;
  localparam byte_t CASE_SHIFT = 8'd32;

  localparam byte_t WORD_DEVICE [6] = '{8'h44, 8'h45, 8'h56, 8'h49, 8'h43, 8'h45};
  localparam byte_t WORD_CDROM  [6] = '{8'h43, 8'h44, 8'h52, 8'h4F, 8'h4D, 8'h30};
  localparam byte_t DEV_PREFIX  [7] = '{8'h44, 8'h45, 8'h56, 8'h49, 8'h43, 8'h45, 8'h5C};

  typedef struct packed {
    logic       comp_open;
    logic [1:0] dots;
    logic       started;
  } rel_state_t;

  typedef struct packed {
    logic       err;
    logic [2:0] status;
    logic       emit;
    logic       sep;
    logic [1:0] dots;
    rel_state_t st;
  } rel_out_t;

  typedef struct packed {
    logic       err;
    logic [2:0] hn;
    rel_state_t st;
  } def_out_t;

  typedef struct packed {
    logic [1:0] kind;
    byte_t      ch;
    logic [2:0] status;
    logic       last;
  } res_t;

  function automatic byte_t to_upper(byte_t c);
    return (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_SHIFT : c;
  endfunction

  function automatic logic is_sep(byte_t c);
    return c == CH_SLASH || c == CH_BSLASH;
  endfunction

  function automatic logic is_bad(byte_t c);
    return c < CH_SPACE || c == CH_STAR || c == CH_QUEST || c == CH_QUOTE ||
           c == CH_LT || c == CH_GT || c == CH_PIPE || c == CH_COLON;
  endfunction

  // one byte of a relative path against the component state
  function automatic rel_out_t rel_step(rel_state_t s, byte_t c);
    rel_out_t r;
    r = '0;
    r.st = s;
    if (is_sep(c)) begin
      if (!s.comp_open && s.dots != 2'd0) begin
        r.err = 1'b1;
        r.status = ST_TRAVERSAL;
      end else begin
        r.st.comp_open = 1'b0;
        r.st.dots = 2'd0;
      end
    end else if (is_bad(c)) begin
      r.err = 1'b1;
      r.status = ST_INVALID;
    end else if (s.comp_open) begin
      r.emit = 1'b1;
    end else if (c == CH_DOT && s.dots != 2'd2) begin
      r.st.dots = s.dots + 2'd1;
    end else begin
      r.emit = 1'b1;
      r.sep = s.started;
      r.dots = s.dots;
      r.st = '{comp_open: 1'b1, dots: 2'd0, started: 1'b1};
    end
    return r;
  endfunction

  // held prefix bytes replayed as relative path; only the first can be special
  function automatic def_out_t go_default(byte_t h0, logic [2:0] cnt);
    def_out_t r;
    r = '0;
    if (is_bad(h0)) begin
      r.err = 1'b1;
    end else if (!is_sep(h0)) begin
      if (h0 == CH_DOT) begin
        r.st.dots = 2'd1;
      end else begin
        r.hn = cnt;
        r.st = '{comp_open: 1'b1, dots: 2'd0, started: 1'b1};
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] rel_finish(rel_state_t s);
    return (!s.comp_open && s.dots != 2'd0) ? ST_TRAVERSAL : ST_OK;
  endfunction

endpackage

// File: hw/rtl/console_path_normalizer.sv
// ----------------------------------------------------------------------------
// console_path_normalizer
// Takes a path one byte per input beat and streams the drive alias, the
// relative path and one end beat with a status. Each accepted beat is decoded
// combinationally and registered into a result buffer of 16 entries, which is
// drained one output beat per cycle while the consumer is ready. A beat that
// causes no result lets the next input beat be taken in the following cycle;
// a beat that causes results (at most 15, for a device alias) holds the input
// until they are drained, and the next beat is taken in the cycle its last
// result is taken. After an error beat the consumer drops what it got for that
// path. No clearing pass after reset.
// ----------------------------------------------------------------------------
module console_path_normalizer
  import cpn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // path_byte
  input  logic        s_tuser,   // has_char
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_byte[7:0], status[10:8], zero[15:11]
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // run_last
);

  localparam logic [2:0] PH_START     = 3'd0;
  localparam logic [2:0] PH_FIRST     = 3'd1;
  localparam logic [2:0] PH_PREFIX    = 3'd2;
  localparam logic [2:0] PH_DEVNAME   = 3'd3;
  localparam logic [2:0] PH_DEVSTREAM = 3'd4;
  localparam logic [2:0] PH_REL       = 3'd5;

  logic [2:0] phase, phase_next;
  byte_t      held [6];
  byte_t      held_next [6];
  logic [2:0] held_count, held_count_next;
  rel_state_t rel, rel_next;
  logic       error_latched, error_latched_next;

  res_t       results [MAX_RESULTS];
  res_t       entries [MAX_RESULTS];
  logic [4:0] fill, rd_ptr;

  logic       s_fire, m_fire, last_take;

  // burst description
  logic       a_single, a_dev, dev_extra;
  byte_t      a_ch, t_ch;
  logic [2:0] dev_n, hn;
  logic       t_emit, t_sep;
  logic [1:0] t_dots;
  logic       e_en;
  logic [2:0] e_status;
  logic [4:0] la, lah, lall, total;
  logic [2:0] lt;

  rel_out_t   rs, gr;
  def_out_t   gd, gd2;

  assign m_fire    = m_tvalid && m_tready;
  assign m_tvalid  = rd_ptr != fill;
  assign last_take = m_fire && (rd_ptr + 5'd1 == fill);
  assign s_tready  = !m_tvalid || last_take;
  assign s_fire    = s_tvalid && s_tready;

  always_comb begin
    phase_next         = phase;
    held_next          = held;
    held_count_next    = held_count;
    rel_next           = rel;
    error_latched_next = error_latched;
    a_single  = 1'b0;
    a_dev     = 1'b0;
    a_ch      = CH_UP_D;
    dev_n     = 3'd0;
    dev_extra = 1'b0;
    hn        = 3'd0;
    t_emit    = 1'b0;
    t_sep     = 1'b0;
    t_dots    = 2'd0;
    t_ch      = s_tdata;
    e_en      = 1'b0;
    e_status  = ST_OK;
    rs  = rel_step(rel, s_tdata);
    gd  = go_default(held[0], held_count);
    gr  = rel_step(gd.st, s_tdata);
    gd2 = '0;

    if (s_tuser && !error_latched) begin
      unique case (phase)
        PH_START: begin
          if (is_sep(s_tdata)) begin
            phase_next = PH_FIRST;
          end else begin
            held_next[0]    = s_tdata;
            held_count_next = 3'd1;
            phase_next      = PH_PREFIX;
          end
        end
        PH_FIRST: begin
          held_next[0]    = s_tdata;
          held_count_next = 3'd1;
          phase_next      = PH_PREFIX;
        end
        PH_PREFIX: begin
          if (held_count == 3'd1 && s_tdata == CH_COLON) begin
            if (to_upper(held[0]) < CH_UP_A || to_upper(held[0]) > CH_UP_Z) begin
              e_en = 1'b1;
              e_status = ST_DRIVE;
              error_latched_next = 1'b1;
            end else begin
              a_single        = 1'b1;
              a_ch            = to_upper(held[0]);
              held_count_next = 3'd0;
              phase_next      = PH_REL;
            end
          end else if (is_sep(s_tdata) && held_count == 3'd6) begin
            held_count_next = 3'd0;
            phase_next      = PH_DEVNAME;
          end else if (!is_sep(s_tdata) && held_count >= 3'd1 && held_count < 3'd6 &&
                       (held_count >= 3'd2 || to_upper(held[0]) == CH_UP_D) &&
                       to_upper(s_tdata) == WORD_DEVICE[held_count]) begin
            held_next[held_count] = s_tdata;
            held_count_next       = held_count + 3'd1;
          end else begin
            a_single        = 1'b1;
            held_count_next = 3'd0;
            phase_next      = PH_REL;
            if (gd.err) begin
              e_en = 1'b1;
              e_status = ST_INVALID;
              error_latched_next = 1'b1;
            end else begin
              hn = gd.hn;
              if (gr.err) begin
                e_en = 1'b1;
                e_status = gr.status;
                error_latched_next = 1'b1;
              end else begin
                t_emit   = gr.emit;
                t_sep    = gr.sep;
                t_dots   = gr.dots;
                rel_next = gr.st;
              end
            end
          end
        end
        PH_DEVNAME: begin
          if (is_sep(s_tdata)) begin
            if (held_count == 3'd6) begin
              a_single = 1'b1;
            end else begin
              a_dev = 1'b1;
              dev_n = held_count;
            end
            held_count_next = 3'd0;
            phase_next      = PH_REL;
          end else if (held_count < 3'd6 &&
                       to_upper(s_tdata) == WORD_CDROM[held_count]) begin
            held_next[held_count] = to_upper(s_tdata);
            held_count_next       = held_count + 3'd1;
          end else begin
            a_dev           = 1'b1;
            dev_n           = held_count;
            dev_extra       = 1'b1;
            a_ch            = to_upper(s_tdata);
            held_count_next = 3'd0;
            phase_next      = PH_DEVSTREAM;
          end
        end
        PH_DEVSTREAM: begin
          if (is_sep(s_tdata)) begin
            phase_next = PH_REL;
          end else begin
            a_single = 1'b1;
            a_ch     = to_upper(s_tdata);
          end
        end
        PH_REL: begin
          if (rs.err) begin
            e_en = 1'b1;
            e_status = rs.status;
            error_latched_next = 1'b1;
          end else begin
            t_emit   = rs.emit;
            t_sep    = rs.sep;
            t_dots   = rs.dots;
            rel_next = rs.st;
          end
        end
        default: begin
          phase_next = PH_START;
        end
      endcase
    end

    // end of path: no-byte beat or last byte
    if (!s_tuser || s_tlast) begin
      if (!error_latched_next) begin
        e_en = 1'b1;
        case (phase_next)
          PH_START: begin
            e_status = ST_EMPTY;
          end
          PH_FIRST: begin
            a_single = 1'b1;
            e_status = ST_OK;
          end
          PH_PREFIX: begin
            if (held_count_next == 3'd6) begin
              e_status = ST_INCOMPLETE;
            end else begin
              a_single = 1'b1;
              gd2 = go_default(held_next[0], held_count_next);
              if (gd2.err) begin
                e_status = ST_INVALID;
              end else begin
                hn = gd2.hn;
                e_status = rel_finish(gd2.st);
              end
            end
          end
          PH_DEVNAME: begin
            if (held_count_next == 3'd6) begin
              a_single = 1'b1;
            end else begin
              a_dev = 1'b1;
              dev_n = held_count_next;
            end
            e_status = rel_finish(rel_next);
          end
          default: begin
            e_status = rel_finish(rel_next);
          end
        endcase
      end
      phase_next         = PH_START;
      held_count_next    = 3'd0;
      rel_next           = '0;
      error_latched_next = 1'b0;
    end
  end

  // lay the burst out: alias, held bytes, tail, end beat
  always_comb begin
    logic [4:0] ii;
    logic [4:0] koff;
    logic [1:0] kk;
    la   = a_dev ? (5'd7 + 5'(dev_n) + 5'(dev_extra)) : 5'(a_single);
    lah  = la + 5'(hn);
    lt   = t_emit ? (3'd1 + 3'(t_sep) + 3'(t_dots)) : 3'd0;
    lall = lah + 5'(lt);
    total = lall + 5'(e_en);
    for (int i = 0; i < MAX_RESULTS; i++) begin
      ii   = 5'(i);
      koff = ii - lah;
      kk   = koff[1:0] - {1'b0, t_sep};
      entries[i] = '{kind: KIND_ALIAS, ch: a_ch, status: ST_OK, last: 1'b0};
      if (ii < la) begin
        if (a_dev && ii < 5'd7) begin
          entries[i].ch = DEV_PREFIX[3'(i)];
        end else if (a_dev && ii < 5'd7 + 5'(dev_n)) begin
          entries[i].ch = held_next[3'(i - 7)];
        end
      end else if (ii < lah) begin
        // held bytes only follow the single default alias
        entries[i].kind = KIND_REL;
        entries[i].ch   = held_next[3'(i - 1)];
      end else if (ii < lall) begin
        entries[i].kind = KIND_REL;
        if (t_sep && koff[1:0] == 2'd0) begin
          entries[i].ch = CH_BSLASH;
        end else if (kk < t_dots) begin
          entries[i].ch = CH_DOT;
        end else begin
          entries[i].ch = t_ch;
        end
      end else begin
        entries[i] = '{kind: KIND_END, ch: 8'd0, status: e_status, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      held_count    <= 3'd0;
      rel           <= '0;
      error_latched <= 1'b0;
      fill          <= 5'd0;
      rd_ptr        <= 5'd0;
    end else if (s_fire) begin
      phase         <= phase_next;
      held_count    <= held_count_next;
      rel           <= rel_next;
      error_latched <= error_latched_next;
      fill          <= total;
      rd_ptr        <= 5'd0;
    end else if (m_fire) begin
      rd_ptr <= rd_ptr + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      held    <= held_next;
      results <= entries;
    end
  end

  res_t cur;
  assign cur     = results[rd_ptr[3:0]];
  assign m_tdata = {5'd0, cur.status, cur.ch};
  assign m_tuser = cur.kind;
  assign m_tlast = cur.last;

endmodule

// File: hw/rtl/cpn_checker.sv
// ----------------------------------------------------------------------------
// cpn_checker
// port-level checks on the path normalizer output stream
// ----------------------------------------------------------------------------
`include "console_path_normalizer_defines.svh"

module cpn_checker
  import cpn_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  `CPN_ASSERT_NOW(a_kind_legal, m_tvalid, m_tuser == KIND_ALIAS || m_tuser == KIND_REL || m_tuser == KIND_END)
  `CPN_ASSERT_NOW(a_last_is_end, m_tvalid, m_tlast == (m_tuser == KIND_END))
  `CPN_ASSERT_NOW(a_char_status_ok, m_tvalid && m_tuser != KIND_END, m_tdata[10:8] == ST_OK)
  `CPN_ASSERT_NOW(a_stall_only_when_busy, !s_tready, m_tvalid)
  `CPN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind console_path_normalizer cpn_checker u_cpn_checker (.*);
